// ===== sv/mop_pkg.sv =====
package mop_pkg;

   // request and response payloads
   typedef struct packed {
      logic [15:0] obj_x;
      logic [15:0] obj_y;
      logic [15:0] scene_x;
      logic [15:0] scene_y;
      logic [15:0] match_score;
      logic        last_match;
   } req_type;

   typedef struct packed {
      logic [5:0] match_index;
      logic       keep;
      logic       last_result;
   } rsp_type;

   // register indexes
   localparam logic [1:0] CSR_ANGLE_SPREAD  = 2'd0;
   localparam logic [1:0] CSR_LENGTH_SPREAD = 2'd1;
   localparam logic [1:0] CSR_SCORE_RATIO   = 2'd2;

   localparam logic [11:0] ANGLE_SPREAD_RST  = 12'd256;
   localparam logic [11:0] LENGTH_SPREAD_RST = 12'd256;
   localparam logic [11:0] SCORE_RATIO_RST   = 12'd768;
   localparam logic [15:0] SCORE_START       = 16'd1600;

   // pi in units of 2^-20 rad
   localparam logic signed [23:0] PI_Q20 = 24'sd3294199;

   // sqrt iterations: one result bit per step for a 34-bit radicand
   localparam int SQRT_STEPS = 17;

   // arctangent of 2^-i in units of 2^-20 rad
   function automatic logic [19:0] mop_atan(input logic [4:0] i);
      logic [19:0] r;
      case (i)
         5'd0:    r = 20'd823550;
         5'd1:    r = 20'd486170;
         5'd2:    r = 20'd256879;
         5'd3:    r = 20'd130396;
         5'd4:    r = 20'd65451;
         5'd5:    r = 20'd32757;
         5'd6:    r = 20'd16383;
         5'd7:    r = 20'd8192;
         5'd8:    r = 20'd4096;
         5'd9:    r = 20'd2048;
         5'd10:   r = 20'd1024;
         5'd11:   r = 20'd512;
         5'd12:   r = 20'd256;
         5'd13:   r = 20'd128;
         5'd14:   r = 20'd64;
         5'd15:   r = 20'd32;
         5'd16:   r = 20'd16;
         5'd17:   r = 20'd8;
         5'd18:   r = 20'd4;
         5'd19:   r = 20'd2;
         5'd20:   r = 20'd1;
         default: r = 20'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/mop_ram.sv =====
module mop_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== sv/match_outlier_pruner_top.sv =====
// Loading one match runs the CORDIC angle and square-root length iterations side by side.
// A set of matches is judged in three passes over the match RAM: two build the sums, and
// a third emits one verdict per match; all products go through one shared multiplier.
// start is ignored while busy is high; verdicts are strobed and cannot be stalled.
// Synchronous reset clears the set state and loads the register defaults; the RAM is not cleared.
module match_outlier_pruner_top
   import mop_pkg::*;
#(
   parameter int MAX_MATCHES  = 64,
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata
);

   localparam int IW     = $clog2(MAX_MATCHES);
   localparam int CW     = $clog2(MAX_MATCHES + 1);
   localparam int ITER_N = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
   localparam int RAM_W  = 16 + 16 + 17;

   typedef enum logic [4:0] {
      S_IDLE, S_SQX, S_SQY, S_ITER, S_WRITE, S_RATIO,
      S_P1_RD, S_P1_ACC,
      S_P2_RD, S_P2_NA, S_P2_AA, S_P2_NL, S_P2_LL,
      S_KA, S_RA_LO, S_RA_HI, S_KL, S_RL_LO, S_RL_HI,
      S_P3_RD, S_P3_NA, S_P3_MA, S_P3_SA, S_P3_NL, S_P3_ML, S_P3_SL, S_EMIT
   } state_type;

   state_type state_ff;

   logic [11:0] angle_spread_ff, length_spread_ff, score_ratio_ff;
   logic [CW-1:0] count_ff, n_ff;
   logic [IW-1:0] idx_ff;
   logic [15:0] min_ff, score_ff;
   logic        last_ff, zero_ff;
   logic signed [16:0] dx_ff, dy_ff;
   logic [33:0] vsq_ff;
   logic [20:0] rem_ff;
   logic [16:0] root_ff;
   logic signed [27:0] cx_ff, cy_ff;
   logic signed [23:0] cz_ff;
   logic [4:0]  step_ff;
   logic [27:0] lim_ff;
   logic signed [23:0] asum_ff, dev_ff;
   logic [23:0] lsum_ff, ksq_ff;
   logic [52:0] asq_ff, lsq_ff;
   logic [48:0] lo_ff;
   logic [60:0] rhs_a_ff, rhs_l_ff;
   logic [29:0] t_ff;
   logic        oka_ff, okl_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   // shared multiplier
   logic [31:0] mul_a;
   logic [27:0] mul_b;
   logic [59:0] mul_p;

   // ram fields
   logic [RAM_W-1:0] ram_rdata;
   logic [15:0]      rd_score;
   logic signed [15:0] rd_angle;
   logic [16:0]      rd_length;
   logic             surv;
   logic [15:0]      abs_angle;
   logic [23:0]      abs_dev;
   logic [16:0]      abs_dx, abs_dy;
   logic             ram_we, ram_re;
   logic [IW-1:0]    ram_raddr;
   logic [RAM_W-1:0] ram_wdata;
   logic signed [23:0] z_round;
   logic [15:0]      angle_out;
   logic             idx_last;

   // cordic and sqrt step
   logic signed [27:0] xs, ys;
   logic [20:0] rem_next, trial;
   logic [76:0] rhs_full;

   assign rd_score  = ram_rdata[RAM_W-1 -: 16];
   assign rd_angle  = ram_rdata[32:17];
   assign rd_length = ram_rdata[16:0];
   assign surv      = {4'd0, rd_score, 8'd0} <= lim_ff;
   assign abs_angle = rd_angle[15] ? 16'(-rd_angle) : 16'(rd_angle);
   assign abs_dev   = dev_ff[23] ? 24'(-dev_ff) : 24'(dev_ff);
   assign abs_dx    = dx_ff[16] ? 17'(-dx_ff) : 17'(dx_ff);
   assign abs_dy    = dy_ff[16] ? 17'(-dy_ff) : 17'(dy_ff);
   assign idx_last  = (CW'(idx_ff) + CW'(1)) == count_ff;
   assign xs        = cx_ff >>> step_ff;
   assign ys        = cy_ff >>> step_ff;
   assign rem_next  = {rem_ff[18:0], vsq_ff[33:32]};
   assign trial     = {2'b00, root_ff, 2'b01};
   assign z_round   = cz_ff + 24'sd128;
   assign angle_out = zero_ff ? 16'd0 : 16'(z_round[23:8]);
   assign mul_p     = 60'(mul_a) * 60'(mul_b);
   assign rhs_full  = {mul_p[51:0], 25'd0} + {28'd0, lo_ff};

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign ram_we    = state_ff == S_WRITE;
   assign ram_wdata = {score_ff, angle_out, root_ff};
   assign ram_re    = state_ff == S_P1_RD || state_ff == S_P2_RD || state_ff == S_P3_RD;
   assign ram_raddr = idx_ff;

   mop_ram #(
      .WIDTH(RAM_W),
      .DEPTH(MAX_MATCHES)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(count_ff[IW-1:0]),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_SQX: begin
            mul_a = 32'(abs_dx);
            mul_b = 28'(abs_dx);
         end
         S_SQY: begin
            mul_a = 32'(abs_dy);
            mul_b = 28'(abs_dy);
         end
         S_RATIO: begin
            mul_a = 32'(score_ratio_ff);
            mul_b = 28'(min_ff);
         end
         S_P2_NA, S_P3_NA: begin
            mul_a = 32'(n_ff);
            mul_b = 28'(abs_angle);
         end
         S_P2_NL, S_P3_NL: begin
            mul_a = 32'(n_ff);
            mul_b = 28'(rd_length);
         end
         S_P2_AA, S_P2_LL: begin
            mul_a = 32'(abs_dev);
            mul_b = 28'(abs_dev);
         end
         S_KA: begin
            mul_a = 32'(angle_spread_ff);
            mul_b = 28'(angle_spread_ff);
         end
         S_KL: begin
            mul_a = 32'(length_spread_ff);
            mul_b = 28'(length_spread_ff);
         end
         S_RA_LO: begin
            mul_a = 32'(ksq_ff);
            mul_b = 28'(asq_ff[24:0]);
         end
         S_RA_HI: begin
            mul_a = 32'(ksq_ff);
            mul_b = asq_ff[52:25];
         end
         S_RL_LO: begin
            mul_a = 32'(ksq_ff);
            mul_b = 28'(lsq_ff[24:0]);
         end
         S_RL_HI: begin
            mul_a = 32'(ksq_ff);
            mul_b = lsq_ff[52:25];
         end
         S_P3_MA, S_P3_ML: begin
            mul_a = 32'(abs_dev);
            mul_b = 28'(n_ff);
         end
         S_P3_SA, S_P3_SL: begin
            mul_a = 32'(t_ff);
            mul_b = 28'(abs_dev);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         count_ff         <= '0;
         min_ff           <= SCORE_START;
         angle_spread_ff  <= ANGLE_SPREAD_RST;
         length_spread_ff <= LENGTH_SPREAD_RST;
         score_ratio_ff   <= SCORE_RATIO_RST;
         rsp_valid_ff     <= 1'b0;
      end else begin
         // verdict strobe for one cycle
         rsp_valid_ff <= state_ff == S_EMIT;
         // register writes
         if (csr_we) begin
            unique case (csr_index)
               CSR_ANGLE_SPREAD:  angle_spread_ff  <= csr_wdata;
               CSR_LENGTH_SPREAD: length_spread_ff <= csr_wdata;
               CSR_SCORE_RATIO:   score_ratio_ff   <= csr_wdata;
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  dx_ff    <= $signed({1'b0, req_data.scene_x}) -
                              $signed({1'b0, req_data.obj_x});
                  dy_ff    <= $signed({1'b0, req_data.scene_y}) -
                              $signed({1'b0, req_data.obj_y});
                  score_ff <= req_data.match_score;
                  last_ff  <= req_data.last_match;
                  if (count_ff < CW'(MAX_MATCHES)) begin
                     state_ff <= S_SQX;
                  end else if (req_data.last_match) begin
                     state_ff <= S_RATIO;
                  end
               end
            end
            S_SQX: begin
               vsq_ff   <= 34'(mul_p[32:0]);
               state_ff <= S_SQY;
            end
            S_SQY: begin
               vsq_ff  <= vsq_ff + 34'(mul_p[32:0]);
               zero_ff <= dx_ff == 17'sd0 && dy_ff == 17'sd0;
               if (dx_ff[16]) begin
                  cx_ff <= -(28'(dx_ff) <<< 8);
                  cy_ff <= -(28'(dy_ff) <<< 8);
                  cz_ff <= dy_ff[16] ? -PI_Q20 : PI_Q20;
               end else begin
                  cx_ff <= 28'(dx_ff) <<< 8;
                  cy_ff <= 28'(dy_ff) <<< 8;
                  cz_ff <= '0;
               end
               rem_ff   <= '0;
               root_ff  <= '0;
               step_ff  <= '0;
               state_ff <= S_ITER;
            end
            S_ITER: begin
               // one cordic rotation
               if (step_ff < 5'(CORDIC_STEPS)) begin
                  if (!cy_ff[27]) begin
                     cx_ff <= cx_ff + ys;
                     cy_ff <= cy_ff - xs;
                     cz_ff <= cz_ff + $signed({4'd0, mop_atan(step_ff)});
                  end else begin
                     cx_ff <= cx_ff - ys;
                     cy_ff <= cy_ff + xs;
                     cz_ff <= cz_ff - $signed({4'd0, mop_atan(step_ff)});
                  end
               end
               // one root bit
               if (step_ff < 5'(SQRT_STEPS)) begin
                  vsq_ff <= {vsq_ff[31:0], 2'b00};
                  if (rem_next >= trial) begin
                     rem_ff  <= rem_next - trial;
                     root_ff <= {root_ff[15:0], 1'b1};
                  end else begin
                     rem_ff  <= rem_next;
                     root_ff <= {root_ff[15:0], 1'b0};
                  end
               end
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'(ITER_N - 1)) begin
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: begin
               if (score_ff < min_ff) begin
                  min_ff <= score_ff;
               end
               count_ff <= count_ff + CW'(1);
               state_ff <= last_ff ? S_RATIO : S_IDLE;
            end
            S_RATIO: begin
               lim_ff   <= mul_p[27:0];
               idx_ff   <= '0;
               n_ff     <= '0;
               asum_ff  <= '0;
               lsum_ff  <= '0;
               asq_ff   <= '0;
               lsq_ff   <= '0;
               state_ff <= S_P1_RD;
            end
            // first pass: survivor count and sums
            S_P1_RD: state_ff <= S_P1_ACC;
            S_P1_ACC: begin
               if (surv) begin
                  n_ff    <= n_ff + CW'(1);
                  asum_ff <= asum_ff + 24'(rd_angle);
                  lsum_ff <= lsum_ff + 24'(rd_length);
               end
               if (idx_last) begin
                  idx_ff   <= '0;
                  state_ff <= S_P2_RD;
               end else begin
                  idx_ff   <= idx_ff + IW'(1);
                  state_ff <= S_P1_RD;
               end
            end
            // second pass: sums of squared deviations
            S_P2_RD: state_ff <= S_P2_NA;
            S_P2_NA, S_P3_NA: begin
               dev_ff   <= (rd_angle[15] ? -$signed(mul_p[23:0]) : $signed(mul_p[23:0]))
                           - asum_ff;
               state_ff <= (state_ff == S_P2_NA) ? S_P2_AA : S_P3_MA;
            end
            S_P2_AA: begin
               if (surv) begin
                  asq_ff <= asq_ff + mul_p[52:0];
               end
               state_ff <= S_P2_NL;
            end
            S_P2_NL, S_P3_NL: begin
               dev_ff   <= $signed(mul_p[23:0]) - $signed(lsum_ff);
               state_ff <= (state_ff == S_P2_NL) ? S_P2_LL : S_P3_ML;
            end
            S_P2_LL: begin
               if (surv) begin
                  lsq_ff <= lsq_ff + mul_p[52:0];
               end
               if (idx_last) begin
                  idx_ff   <= '0;
                  state_ff <= S_KA;
               end else begin
                  idx_ff   <= idx_ff + IW'(1);
                  state_ff <= S_P2_RD;
               end
            end
            // right-hand sides: spread squared times sum of squares
            S_KA: begin
               ksq_ff   <= mul_p[23:0];
               state_ff <= S_RA_LO;
            end
            S_RA_LO: begin
               lo_ff    <= mul_p[48:0];
               state_ff <= S_RA_HI;
            end
            S_RA_HI: begin
               rhs_a_ff <= rhs_full[76:16];
               state_ff <= S_KL;
            end
            S_KL: begin
               ksq_ff   <= mul_p[23:0];
               state_ff <= S_RL_LO;
            end
            S_RL_LO: begin
               lo_ff    <= mul_p[48:0];
               state_ff <= S_RL_HI;
            end
            S_RL_HI: begin
               rhs_l_ff <= rhs_full[76:16];
               state_ff <= S_P3_RD;
            end
            // third pass: spread tests and verdicts
            S_P3_RD: state_ff <= S_P3_NA;
            S_P3_MA, S_P3_ML: begin
               t_ff     <= mul_p[29:0];
               state_ff <= (state_ff == S_P3_MA) ? S_P3_SA : S_P3_SL;
            end
            S_P3_SA: begin
               oka_ff   <= {8'd0, mul_p[52:0]} <= rhs_a_ff;
               state_ff <= S_P3_NL;
            end
            S_P3_SL: begin
               okl_ff   <= {8'd0, mul_p[52:0]} <= rhs_l_ff;
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               rsp_ff.match_index  <= 6'(idx_ff);
               rsp_ff.keep         <= surv && oka_ff && okl_ff;
               rsp_ff.last_result  <= idx_last;
               if (idx_last) begin
                  count_ff <= '0;
                  min_ff   <= SCORE_START;
                  state_ff <= S_IDLE;
               end else begin
                  idx_ff   <= idx_ff + IW'(1);
                  state_ff <= S_P3_RD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
